// ===== hw/rtl/disparity_to_topdown_grid_macros.svh =====
// Assertion macros for the disparity to top-down grid block.
`ifndef DISPARITY_TO_TOPDOWN_GRID_MACROS_SVH
`define DISPARITY_TO_TOPDOWN_GRID_MACROS_SVH
`ifndef SYNTH
`define D2G_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define D2G_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define D2G_ASSERT_IMPL(label, clk, rst, ante, cons)
`define D2G_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/d2g_pkg.sv =====
// ----------------------------------------------------------------------------
// d2g_pkg
// Shared types, codes and constants of the disparity to top-down grid block.
// ----------------------------------------------------------------------------
package d2g_pkg;
   localparam int GRID_COLS_DEF = 40;
   localparam int GRID_ROWS_DEF = 20;
   localparam int ROW_OUT_W = 40;

   localparam logic [1:0] CMD_PROJECT = 2'd0;
   localparam logic [1:0] CMD_CLEAR   = 2'd1;
   localparam logic [1:0] CMD_READ    = 2'd2;

   localparam logic [2:0] REG_FOCAL_BASELINE = 3'd0;
   localparam logic [2:0] REG_CENTER_COLUMN  = 3'd1;
   localparam logic [2:0] REG_INV_FOCAL      = 3'd2;
   localparam logic [2:0] REG_CELL_SIZE      = 3'd3;
   localparam logic [2:0] REG_MAX_DEPTH      = 3'd4;
   localparam logic [2:0] REG_HALF_WIDTH     = 3'd5;

   localparam logic [15:0] DISP_MAX = 16'd128;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_ZDIV, ST_MUL1, ST_MUL2, ST_LAT, ST_XDIV, ST_ZQDIV,
      ST_MARK, ST_CLEAR, ST_RESP
   } state_type;

   typedef struct packed {
      logic load;      // capture input transaction
      logic zdiv_start;
      logic mul1;
      logic mul2;
      logic lat;
      logic xdiv_start;
      logic zqdiv_start;
      logic mark;
      logic clear;
      logic read;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic disp_ok;   // disparity in range
      logic z_ok;      // depth within max and cell size nonzero
      logic x_ok;
      logic z_row_ok;
      logic clear_done;
   } status_type;
endpackage

// ===== hw/rtl/disparity_to_topdown_grid.sv =====
// ----------------------------------------------------------------------------
// disparity_to_topdown_grid
// Projects stereo disparity pixels onto a top-down occupancy bit grid.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A projection runs three divisions on
// one shared radix-2 divider of 49 quotient bits each (depth, lateral cell,
// depth cell), plus the multiply, lateral and mark steps. A clear sweeps the
// grid one row a cycle. A read or an unused command goes straight to the
// response. After reset the block runs the same sweep once, so the input
// stays stalled until that sweep is done. The result register is the skid
// point.
module disparity_to_topdown_grid #(
   parameter int GRID_COLS = d2g_pkg::GRID_COLS_DEF,
   parameter int GRID_ROWS = d2g_pkg::GRID_ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [9:0]  req_column,
   input  logic [15:0] req_disparity,
   input  logic [5:0]  req_row_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_marked,
   output logic [5:0]  rsp_cell_column,
   output logic [5:0]  rsp_cell_row,
   output logic [d2g_pkg::ROW_OUT_W-1:0] rsp_row_bits
);
   import d2g_pkg::*;
`include "disparity_to_topdown_grid_macros.svh"
   cmd_type    cmd;
   status_type status;
   logic [5:0] gx, gz;

   d2g_control u_ctl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .status(status), .cmd(cmd), .marked(rsp_marked)
   );

   d2g_datapath #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_dp (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .req_column(req_column), .req_disparity(req_disparity),
      .req_row_index(req_row_index), .cmd(cmd), .status(status), .gx(gx), .gz(gz),
      .row_out(rsp_row_bits)
   );

   // Cell indexes are shown only when the pixel marked a cell.
   assign rsp_cell_column = rsp_marked ? gx : 6'd0;
   assign rsp_cell_row    = rsp_marked ? gz : 6'd0;

   `D2G_ASSERT_IMPL(a_no_take_busy, clock, reset, rsp_valid && rsp_stall, req_stall)
   `D2G_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `D2G_ASSERT_IMPL(a_mark_clean, clock, reset, rsp_valid && !rsp_marked,
      rsp_cell_column == 6'd0 && rsp_cell_row == 6'd0)
endmodule

// ===== hw/rtl/d2g_divider.sv =====
// ----------------------------------------------------------------------------
// d2g_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module d2g_divider #(
   parameter int NUM_W = 49,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [DEN_W-1:0] d_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      trial   = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      q_in    = q_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         q_in    = numer;
         r_in    = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      if (start) d_ff <= denom;
   end

   assign done = busy_ff && (cnt_ff == CNT_W'(1));
   assign quot = q_in;
endmodule

// ===== hw/rtl/d2g_datapath.sv =====
// ----------------------------------------------------------------------------
// d2g_datapath
// Registers, arithmetic, divider and occupancy store of the grid block.
// ----------------------------------------------------------------------------
module d2g_datapath #(
   parameter int GRID_COLS = d2g_pkg::GRID_COLS_DEF,
   parameter int GRID_ROWS = d2g_pkg::GRID_ROWS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_data,
   input  logic [9:0]           req_column,
   input  logic [15:0]          req_disparity,
   input  logic [5:0]           req_row_index,
   input  d2g_pkg::cmd_type     cmd,
   output d2g_pkg::status_type  status,
   output logic [5:0]           gx,
   output logic [5:0]           gz,
   output logic [d2g_pkg::ROW_OUT_W-1:0] row_out
);
   import d2g_pkg::*;
   localparam int RA_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int CA_W = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;

   logic [31:0] fb_ff, md_ff, hw_ff;
   logic [15:0] cc_ff, cs_ff;
   logic [23:0] if_ff;
   logic [9:0]  col_ff;
   logic [15:0] disp_ff;
   logic [5:0]  ridx_ff;
   logic [31:0] z_ff;
   logic [47:0] p_ff;     // |diff| * z
   logic        neg_ff;
   logic [48:0] prod_lo_ff, prod_hi_ff;
   logic [48:0] lat_ff;
   logic        latneg_ff;
   logic [48:0] qx_ff;
   logic [RA_W-1:0] clr_ff;
   logic [GRID_COLS-1:0] rows_ff [GRID_ROWS];

   logic        div_start, div_done;
   logic [48:0] div_num, div_q;
   logic [19:0] colq;
   logic [19:0] diff;
   logic [48:0] mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_ff <= 32'd1572864; cc_ff <= 16'd5120; if_ff <= 24'd41943;
         cs_ff <= 16'd3277;    md_ff <= 32'd65536; hw_ff <= 32'd65536;
      end else if (csr_write) begin
         case (csr_index)
            REG_FOCAL_BASELINE: fb_ff <= csr_data;
            REG_CENTER_COLUMN:  cc_ff <= csr_data[15:0];
            REG_INV_FOCAL:      if_ff <= csr_data[23:0];
            REG_CELL_SIZE:      cs_ff <= csr_data[15:0];
            REG_MAX_DEPTH:      md_ff <= csr_data;
            REG_HALF_WIDTH:     hw_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign colq = {6'd0, col_ff, 4'd0};
   assign diff = neg_ff ? ({4'd0, cc_ff} - colq) : (colq - {4'd0, cc_ff});
   // The low nibble of the high product is folded into the low sum before
   // the shift, so the result is the exact product shifted right by 28.
   assign mag  = (prod_hi_ff >> 4)
               + (({21'd0, prod_hi_ff[3:0], 24'd0} + prod_lo_ff) >> 28);

   assign div_start = cmd.zdiv_start | cmd.xdiv_start | cmd.zqdiv_start;
   always_comb begin
      if (cmd.zdiv_start)      div_num = {17'd0, fb_ff};
      else if (cmd.xdiv_start) div_num = lat_ff;
      else                     div_num = {17'd0, z_ff};
   end

   d2g_divider #(.NUM_W(49), .DEN_W(32)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .numer(div_num),
      .denom(cmd.zdiv_start ? {16'd0, req_disparity} : {16'd0, cs_ff}),
      .done(div_done), .quot(div_q)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         col_ff <= req_column; disp_ff <= req_disparity; ridx_ff <= req_row_index;
      end
      if (cmd.zdiv_start) neg_ff <= ({6'd0, req_column, 4'd0} < {4'd0, cc_ff});
      if (cmd.mul1) p_ff <= {28'd0, diff} * {16'd0, z_ff};
      if (cmd.mul2) begin
         // Split product keeps each multiplier near 24 x 24.
         prod_lo_ff <= 49'({24'd0, p_ff[23:0]} * {24'd0, if_ff});
         prod_hi_ff <= 49'({24'd0, p_ff[47:24]} * {24'd0, if_ff});
      end
      if (cmd.lat) begin
         if (neg_ff) begin
            lat_ff <= {17'd0, hw_ff} + mag; latneg_ff <= 1'b0;
         end else if (mag <= {17'd0, hw_ff}) begin
            lat_ff <= {17'd0, hw_ff} - mag; latneg_ff <= 1'b0;
         end else begin
            lat_ff <= mag - {17'd0, hw_ff}; latneg_ff <= 1'b1;
         end
      end
   end

   // Quotient capture: controller phase tells which division finished.
   logic [1:0] phase_ff;
   always_ff @(posedge clock) begin
      if (reset) phase_ff <= 2'd0;
      else if (cmd.zdiv_start) phase_ff <= 2'd0;
      else if (cmd.xdiv_start) phase_ff <= 2'd1;
      else if (cmd.zqdiv_start) phase_ff <= 2'd2;
      if (div_done) begin
         case (phase_ff)
            2'd0: z_ff  <= div_q[31:0];
            2'd1: qx_ff <= div_q;
            default: gz <= div_q[5:0];
         endcase
      end
   end
   logic [48:0] qz_full_ff;
   always_ff @(posedge clock) if (div_done && phase_ff == 2'd2) qz_full_ff <= div_q;

   assign gx = qx_ff[5:0];

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear) clr_ff <= (clr_ff == RA_W'(GRID_ROWS-1)) ? '0 : clr_ff + 1'b1;
      if (cmd.clear) rows_ff[clr_ff] <= '0;
      else if (cmd.mark) rows_ff[qz_full_ff[RA_W-1:0]][qx_ff[CA_W-1:0]] <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) row_out <= '0;
      else if (cmd.read) begin
         if ({1'b0, ridx_ff} < 7'(GRID_ROWS))
            row_out <= ROW_OUT_W'(rows_ff[ridx_ff[RA_W-1:0]]);
         else row_out <= '0;
      end
   end

   assign status.div_done   = div_done;
   assign status.disp_ok    = (disp_ff != 16'd0) && (disp_ff <= DISP_MAX);
   assign status.z_ok       = (z_ff <= md_ff) && (cs_ff != 16'd0);
   assign status.x_ok       = !(latneg_ff && qx_ff != '0) && (qx_ff < 49'(GRID_COLS));
   assign status.z_row_ok   = qz_full_ff < 49'(GRID_ROWS);
   assign status.clear_done = clr_ff == RA_W'(GRID_ROWS-1);
endmodule

// ===== hw/rtl/d2g_control.sv =====
// ----------------------------------------------------------------------------
// d2g_control
// Sequencer that steps one transaction through the datapath.
// ----------------------------------------------------------------------------
module d2g_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_command,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  d2g_pkg::status_type status,
   output d2g_pkg::cmd_type    cmd,
   output logic                marked
);
   import d2g_pkg::*;
   state_type st_ff, st_in;
   logic [1:0] op_ff;
   logic mk_ff, mk_in, rv_ff, rv_in;
   logic take;

   assign req_stall = (st_ff != ST_IDLE) || (rv_ff && rsp_stall);
   assign take = req_valid && !req_stall;
   assign rsp_valid = rv_ff;
   assign marked = mk_ff;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_INIT:  if (status.clear_done) st_in = ST_IDLE;
         ST_IDLE: if (take) begin
            case (req_command)
               CMD_PROJECT: st_in = ST_ZDIV;
               CMD_CLEAR:   st_in = ST_CLEAR;
               default:     st_in = ST_RESP;
            endcase
         end
         ST_ZDIV:  if (status.div_done) st_in = ST_MUL1;
         ST_MUL1:  st_in = (status.disp_ok && status.z_ok) ? ST_MUL2 : ST_RESP;
         ST_MUL2:  st_in = ST_LAT;
         ST_LAT:   st_in = ST_XDIV;
         ST_XDIV:  if (status.div_done) st_in = ST_ZQDIV;
         ST_ZQDIV: if (status.div_done) st_in = ST_MARK;
         ST_MARK:  st_in = ST_RESP;
         ST_CLEAR: if (status.clear_done) st_in = ST_RESP;
         ST_RESP:  if (!rv_ff || !rsp_stall) st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
   end

   logic xdiv_go_ff, zq_go_ff;
   always_comb begin
      cmd = '0;
      cmd.load = take;
      case (st_ff)
         ST_INIT:  cmd.clear = 1'b1;
         ST_IDLE:  cmd.zdiv_start = take && (req_command == CMD_PROJECT);
         ST_MUL1:  cmd.mul1 = 1'b1;
         ST_MUL2:  cmd.mul2 = 1'b1;
         ST_LAT:   cmd.lat = 1'b1;
         ST_XDIV:  cmd.xdiv_start = xdiv_go_ff;
         ST_ZQDIV: cmd.zqdiv_start = zq_go_ff;
         ST_MARK:  cmd.mark = status.x_ok && status.z_row_ok;
         ST_CLEAR: cmd.clear = 1'b1;
         ST_RESP:  cmd.read = (op_ff == CMD_READ) && (!rv_ff || !rsp_stall);
         default:  ;
      endcase
   end

   always_comb begin
      mk_in = mk_ff;
      rv_in = rv_ff && rsp_stall;
      if (take) mk_in = 1'b0;
      if (st_ff == ST_MARK) mk_in = status.x_ok && status.z_row_ok;
      if (st_ff == ST_RESP && (!rv_ff || !rsp_stall)) rv_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_INIT; rv_ff <= 1'b0; mk_ff <= 1'b0; op_ff <= CMD_PROJECT;
         xdiv_go_ff <= 1'b0; zq_go_ff <= 1'b0;
      end else begin
         st_ff <= st_in; rv_ff <= rv_in; mk_ff <= mk_in;
         if (take) op_ff <= req_command;
         xdiv_go_ff <= (st_in == ST_XDIV) && (st_ff != ST_XDIV);
         zq_go_ff   <= (st_in == ST_ZQDIV) && (st_ff != ST_ZQDIV);
      end
   end
endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for disparity_to_topdown_grid
// Drives projection, clear, read and unused-command transactions through the
// request channel. A behavioral occupancy grid predicts every response, and
// the responses are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import d2g_pkg::*;

   localparam int NCOLS = 40;
   localparam int NROWS = 20;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int LIMIT_CYCLES = 2000000;

   typedef struct packed {
      logic [1:0]  command;
      logic [9:0]  column;
      logic [15:0] disparity;
      logic [5:0]  row_index;
   } pixel_req_type;

   typedef struct packed {
      logic        marked;
      logic [5:0]  cell_column;
      logic [5:0]  cell_row;
      logic [39:0] row_bits;
   } grid_rsp_type;

   // One directed row: the request, and an expected response that is typed
   // in only where it is obvious; other rows use the predictor.
   typedef struct {
      pixel_req_type req;
      bit            fixed;
      grid_rsp_type  rsp;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_command = '0;
   logic [9:0] req_column = '0;
   logic [15:0] req_disparity = '0;
   logic [5:0] req_row_index = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_marked;
   logic [5:0] rsp_cell_column;
   logic [5:0] rsp_cell_row;
   logic [39:0] rsp_row_bits;

   // Predictor copy of the configuration and the grid.
   logic [31:0] m_focal_baseline, m_max_depth, m_half_width;
   logic [15:0] m_center_column, m_cell_size;
   logic [23:0] m_inv_focal;
   logic [NCOLS-1:0] m_grid [NROWS];

   grid_rsp_type expected_rsps[$];
   int mismatches = 0;
   int checked = 0;
   int marked_seen = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_off = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   disparity_to_topdown_grid i_dut (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .req_valid, .req_stall, .req_command, .req_column, .req_disparity,
      .req_row_index, .rsp_valid, .rsp_stall, .rsp_marked, .rsp_cell_column,
      .rsp_cell_row, .rsp_row_bits
   );

   // Global watchdog. The limit leaves a wide margin over the slowest
   // projection even with heavy idling on both sides.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("testbench NOT OK");
         $finish;
      end
   end

   function automatic void reset_model();
      m_focal_baseline = 32'd1572864;
      m_center_column = 16'd5120;
      m_inv_focal = 24'd41943;
      m_cell_size = 16'd3277;
      m_max_depth = 32'd65536;
      m_half_width = 32'd65536;
      foreach (m_grid[r]) m_grid[r] = '0;
   endfunction

   // Finds the grid cell a pixel falls in. The lateral magnitude is computed
   // exactly at full width before truncation to Q16.16.
   function automatic bit locate_cell(input logic [9:0] col, input logic [15:0] disp,
                                      output int gx, output int gz);
      logic [63:0] depth, colq, diff, lat, qx, qz;
      logic [127:0] mag_full;
      logic [63:0] mag;
      bit diff_neg, lat_neg;
      gx = 0;
      gz = 0;
      if (disp < 16'd1 || disp > DISP_MAX) return 1'b0;
      depth = 64'(m_focal_baseline) / 64'(disp);
      if (depth > 64'(m_max_depth)) return 1'b0;
      if (m_cell_size == 0) return 1'b0;
      colq = 64'(col) * 16;
      diff_neg = colq < 64'(m_center_column);
      diff = diff_neg ? 64'(m_center_column) - colq : colq - 64'(m_center_column);
      mag_full = 128'(diff) * 128'(depth) * 128'(m_inv_focal);
      mag = 64'(mag_full >> 28);
      if (diff_neg) begin
         lat = 64'(m_half_width) + mag;
         lat_neg = 1'b0;
      end else if (mag <= 64'(m_half_width)) begin
         lat = 64'(m_half_width) - mag;
         lat_neg = 1'b0;
      end else begin
         lat = mag - 64'(m_half_width);
         lat_neg = 1'b1;
      end
      qx = lat / 64'(m_cell_size);
      if (lat_neg && qx != 0) return 1'b0;
      if (qx >= NCOLS) return 1'b0;
      qz = depth / 64'(m_cell_size);
      if (qz >= NROWS) return 1'b0;
      gx = int'(qx);
      gz = int'(qz);
      return 1'b1;
   endfunction

   function automatic grid_rsp_type predict_grid_rsp(input pixel_req_type rq);
      grid_rsp_type r;
      int gx, gz;
      r = '0;
      case (rq.command)
         CMD_PROJECT: begin
            if (locate_cell(rq.column, rq.disparity, gx, gz)) begin
               m_grid[gz][gx] = 1'b1;
               r.marked = 1'b1;
               r.cell_column = 6'(gx);
               r.cell_row = 6'(gz);
            end
         end
         CMD_CLEAR: begin
            foreach (m_grid[i]) m_grid[i] = '0;
         end
         CMD_READ: begin
            if (rq.row_index < NROWS) r.row_bits = 40'(m_grid[rq.row_index]);
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_FOCAL_BASELINE: m_focal_baseline = value;
         REG_CENTER_COLUMN:  m_center_column = value[15:0];
         REG_INV_FOCAL:      m_inv_focal = value[23:0];
         REG_CELL_SIZE:      m_cell_size = value[15:0];
         REG_MAX_DEPTH:      m_max_depth = value;
         REG_HALF_WIDTH:     m_half_width = value;
         default: ;
      endcase
   endtask

   // Sends one transaction at the falling edge and holds it until the block
   // takes it. Valid stays up until the next falling edge, where the next
   // transaction or an idle cycle replaces it. The expectation is queued when
   // the handshake completes, so an override from the directed table replaces
   // the predicted value.
   task automatic send_req(input pixel_req_type rq, input bit fixed,
                           input grid_rsp_type fixed_rsp);
      grid_rsp_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= rq.command;
      req_column <= rq.column;
      req_disparity <= rq.disparity;
      req_row_index <= rq.row_index;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_grid_rsp(rq);
      expected_rsps.push_back(fixed ? fixed_rsp : predicted);
   endtask

   // The block is idle once every response has come back; it holds nothing
   // that produces no response, but a margin of idle clocks is added.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Random projection built to land on the grid most of the time: a
   // disparity near the one that maps to depths inside max_depth.
   function automatic pixel_req_type random_req();
      pixel_req_type rq;
      int pick;
      rq.command = CMD_PROJECT;
      rq.column = 10'($urandom);
      rq.row_index = 6'($urandom_range(NROWS - 1));
      pick = $urandom_range(99);
      if (pick < 70) rq.disparity = 16'($urandom_range(24, 128));
      else if (pick < 80) rq.disparity = 16'($urandom_range(1, 23));
      else if (pick < 88) rq.disparity = 16'($urandom);
      else rq.disparity = 16'($urandom_range(129, 300));
      pick = $urandom_range(99);
      if (pick < 12) rq.command = CMD_READ;
      else if (pick < 14) rq.command = CMD_CLEAR;
      else if (pick < 16) rq.command = CMD_UNUSED;
      if (rq.command == CMD_READ && $urandom_range(9) == 0)
         rq.row_index = 6'($urandom);
      return rq;
   endfunction

   // Responses are sampled at the rising edge; the stall changes only at the
   // falling edge. A long hold-off is requested by the stimulus process.
   always @(posedge clock) begin
      grid_rsp_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_marked, rsp_cell_column, rsp_cell_row, rsp_row_bits};
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
         end else begin
            want = expected_rsps.pop_front();
            checked++;
            if (got.marked) marked_seen++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
   end

   directed_row_type directed[$];

   function automatic directed_row_type row(input logic [1:0] c, input logic [9:0] col,
                                            input logic [15:0] d, input logic [5:0] ri,
                                            input bit fixed, input grid_rsp_type r);
      directed_row_type x;
      x.req = '{c, col, d, ri};
      x.fixed = fixed;
      x.rsp = r;
      return x;
   endfunction

   initial begin
      int phase;
      int count;
      int hold_cycles;
      pixel_req_type rq;
      reset_model();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table. With the reset settings a pixel at column 320 has no
      // lateral offset and lands in the middle column.
      directed.push_back(row(CMD_READ, 0, 0, 0, 1, '0));           // empty after reset
      directed.push_back(row(CMD_PROJECT, 0, 0, 0, 1, '0));        // zero disparity
      directed.push_back(row(CMD_PROJECT, 1023, 65535, 0, 1, '0)); // disparity far out
      directed.push_back(row(CMD_PROJECT, 320, 129, 0, 1, '0));    // just past the top
      directed.push_back(row(CMD_PROJECT, 320, 1, 0, 1, '0));      // too deep
      directed.push_back(row(CMD_PROJECT, 320, 128, 0, 0, '0));
      directed.push_back(row(CMD_PROJECT, 320, 24, 0, 0, '0));
      directed.push_back(row(CMD_PROJECT, 0, 100, 0, 0, '0));
      directed.push_back(row(CMD_PROJECT, 1023, 100, 0, 0, '0));
      directed.push_back(row(CMD_PROJECT, 330, 60, 0, 0, '0));
      directed.push_back(row(CMD_PROJECT, 600, 30, 0, 0, '0));
      directed.push_back(row(CMD_READ, 0, 0, 19, 0, '0));
      directed.push_back(row(CMD_READ, 0, 0, 7, 0, '0));
      directed.push_back(row(CMD_READ, 0, 0, 20, 1, '0));          // row out of range
      directed.push_back(row(CMD_READ, 0, 0, 63, 1, '0));
      directed.push_back(row(CMD_UNUSED, 1023, 65535, 63, 1, '0)); // unused command
      directed.push_back(row(CMD_CLEAR, 1023, 65535, 63, 1, '0));
      directed.push_back(row(CMD_READ, 0, 0, 5, 1, '0));           // grid empty again
      foreach (directed[i]) send_req(directed[i].req, directed[i].fixed, directed[i].rsp);
      wait_idle();

      // Small negative lateral: half width zero and a pixel just right of
      // center, so the lateral value is a hair below zero and still marks
      // column zero.
      write_reg(REG_HALF_WIDTH, 32'd0);
      send_req('{CMD_PROJECT, 10'd321, 16'd60, 6'd0}, 0, '0);
      send_req('{CMD_PROJECT, 10'd400, 16'd60, 6'd0}, 0, '0);
      wait_idle();
      // Zero cell size never marks.
      write_reg(REG_CELL_SIZE, 32'd0);
      send_req('{CMD_PROJECT, 10'd320, 16'd60, 6'd0}, 1, '0);
      wait_idle();

      // Random phases with varying settings and idling. The first phases
      // use the reset-like geometry, later ones sweep register extremes.
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_reg(REG_FOCAL_BASELINE, 32'd1572864);
               write_reg(REG_CENTER_COLUMN, 32'd5120);
               write_reg(REG_INV_FOCAL, 32'd41943);
               write_reg(REG_CELL_SIZE, 32'd3277);
               write_reg(REG_MAX_DEPTH, 32'd65536);
               write_reg(REG_HALF_WIDTH, 32'd65536);
               send_idle_pct = 0;  recv_stall_pct = 0;
            end
            1: begin send_idle_pct = 53; recv_stall_pct = 0; end
            2: begin
               write_reg(REG_CELL_SIZE, 32'd1);
               write_reg(REG_HALF_WIDTH, 32'd20);
               write_reg(REG_FOCAL_BASELINE, 32'd2000);
               write_reg(REG_MAX_DEPTH, 32'hFFFF_FFFF);
               send_idle_pct = 0;  recv_stall_pct = 53;
            end
            3: begin
               write_reg(REG_FOCAL_BASELINE, 32'hFFFF_FFFF);
               write_reg(REG_CENTER_COLUMN, 32'h0000_FFFF);
               write_reg(REG_INV_FOCAL, 32'h00FF_FFFF);
               write_reg(REG_CELL_SIZE, 32'h0000_FFFF);
               write_reg(REG_MAX_DEPTH, 32'hFFFF_FFFF);
               write_reg(REG_HALF_WIDTH, 32'hFFFF_FFFF);
               send_idle_pct = 25; recv_stall_pct = 25;
            end
            4: begin
               write_reg(REG_FOCAL_BASELINE, 32'd0);
               write_reg(REG_CENTER_COLUMN, 32'd0);
               write_reg(REG_INV_FOCAL, 32'd0);
               write_reg(REG_MAX_DEPTH, 32'd0);
               write_reg(REG_HALF_WIDTH, 32'd0);
               send_idle_pct = 0;  recv_stall_pct = 0;
            end
            default: begin
               write_reg(REG_FOCAL_BASELINE, 32'd3000000);
               write_reg(REG_CENTER_COLUMN, 32'd8000);
               write_reg(REG_INV_FOCAL, 32'd60000);
               write_reg(REG_CELL_SIZE, 32'd2000);
               write_reg(REG_MAX_DEPTH, 32'd200000);
               write_reg(REG_HALF_WIDTH, 32'd40000);
               send_idle_pct = 25; recv_stall_pct = 25;
            end
         endcase
         for (count = 0; count < 85; count++) begin
            // In one phase the receiver holds off for a long stretch while
            // transactions keep coming, so the result register fills up.
            if (phase == 1 && count == 10) begin
               fork
                  begin
                     hold_off = 1'b1;
                     for (hold_cycles = 0; hold_cycles < 600; hold_cycles++)
                        @(posedge clock);
                     hold_off = 1'b0;
                  end
               join_none
            end
            rq = random_req();
            send_req(rq, 0, '0);
         end
         wait_idle();
      end

      repeat (200) @(posedge clock);
      $display("checked %0d responses, %0d marked a cell, across 6 register settings",
               checked, marked_seen);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches, expected_rsps.size());
         $display("testbench NOT OK");
      end
      $finish;
   end
endmodule
